@@ rtl/tpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants of the line/column pattern matcher
// Payload structs, the cell link and control structs, the sequencer states
// and a saturating-increment helper, used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int SYM_W       = 21;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 7;
  localparam int PIDX_W      = 6;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [SYM_W-1:0] NEWLINE_CP = SYM_W'(10);
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

  // command codes of an input transaction
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SYM_W-1:0]  symbol;
    logic [PIDX_W-1:0] pattern_index;
    logic              first_in_file;
  } tpm_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] match_line;
    logic [CNT_W-1:0] match_column;
    logic [CNT_W-1:0] hits_so_far;
    logic [CNT_W-1:0] files_hit;
  } tpm_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] line;
    logic [CNT_W-1:0] column;
  } tpm_pos_t;

  // what one cell hands to its neighbour
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    tpm_pos_t         pos;
    logic             valid;
    logic [SYM_W-1:0] pattern;
    logic             mask;
    logic             marker;
  } tpm_link_t;

  // control broadcast to every cell
  typedef struct packed {
    logic             text_shift;
    logic             first;
    logic             pat_shift;
    logic             pat_clear;
    logic [SYM_W-1:0] pat_wdata;
  } tpm_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD
  } tpm_state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

endpackage

@@ rtl/tpm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tpm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_cell: one position of the text window and of the aligned pattern
// Holds a text symbol with its start position and the pattern symbol it
// is compared against; both shift towards the next cell.
// ----------------------------------------------------------------------------
module tpm_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tpm_pkg::tpm_cell_ctrl_t ctrl_i,
  input  logic                   pat_wr_i,
  input  tpm_pkg::tpm_link_t     prev_i,
  output tpm_pkg::tpm_link_t     next_o,
  output logic                   ok_o
);

  logic [tpm_pkg::SYM_W-1:0] win_q;
  logic [tpm_pkg::SYM_W-1:0] pat_q;
  tpm_pkg::tpm_pos_t         pos_q;
  logic                      valid_q;
  logic                      mask_q;
  logic                      marker_q;

  // control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      mask_q   <= 1'b0;
      marker_q <= 1'b0;
    end else begin
      if (ctrl_i.text_shift) begin
        valid_q <= prev_i.valid;
      end
      if (ctrl_i.pat_clear) begin
        mask_q   <= 1'b0;
        marker_q <= 1'b0;
      end else if (ctrl_i.pat_shift) begin
        mask_q   <= prev_i.mask;
        marker_q <= prev_i.marker;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.text_shift) begin
      win_q <= prev_i.symbol;
      pos_q <= prev_i.pos;
    end
    if (ctrl_i.pat_shift) begin
      pat_q <= prev_i.pattern;
    end else if (pat_wr_i) begin
      pat_q <= ctrl_i.pat_wdata;
    end
  end

  // a new file drops everything older than the incoming symbol
  always_comb begin
    next_o.symbol  = win_q;
    next_o.pos     = pos_q;
    next_o.valid   = valid_q & ~(ctrl_i.text_shift & ctrl_i.first);
    next_o.pattern = pat_q;
    next_o.mask    = mask_q;
    next_o.marker  = marker_q;
  end

  assign ok_o = ~mask_q | (valid_q & (win_q == pat_q));

endmodule

@@ rtl/text_pattern_match_line_col_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_pattern_match_line_col_core: streaming exact substring search
// Chain of compare cells with line/column tracking and saturating counters.
// ----------------------------------------------------------------------------
// Searches a stream of code points, split into files, for a loaded pattern
// and reports the line and column (counted in code points from 1) at which
// each match starts, with the running hit count and the count of files
// with hits. A text transaction shifts the window chain in the accept
// cycle and sets eval_q; all cells are then compared, and the match start
// picked out, once the output register is free, with in_stall_o high until
// then. A result is held in an output register, so the next transaction is
// taken while it waits; a second result waits for the first to be taken.
// Writing query_length realigns the pattern chain from the pattern RAM,
// one symbol per cycle, the length saturating to MAX_PATTERN; after reset
// a realignment of length 1 runs.
// ----------------------------------------------------------------------------
module text_pattern_match_line_col_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tpm_pkg::tpm_in_t                 in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tpm_pkg::tpm_out_t                out_data_o,
  // query_length write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tpm_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int N = tpm_pkg::MAX_PATTERN;

  // sequencer for pattern realignment
  tpm_pkg::tpm_state_e            state_q, state_d;
  logic [tpm_pkg::LEN_W-1:0]      len_q, len_d;
  logic [tpm_pkg::LEN_W-1:0]      cnt_q, cnt_d;
  logic [tpm_pkg::LEN_W-1:0]      cnt_inc;
  logic [tpm_pkg::IDX_W-1:0]      ram_raddr;
  logic [tpm_pkg::SYM_W-1:0]      ram_rdata;
  tpm_pkg::tpm_cell_ctrl_t        ctrl;

  // text position and counters
  logic [tpm_pkg::CNT_W-1:0]      line_q, column_q;
  logic [tpm_pkg::CNT_W-1:0]      hits_q, files_q;
  logic                           file_has_hit_q;
  logic                           eval_q;
  logic                           out_valid_q;
  tpm_pkg::tpm_out_t              out_q;

  // handshake decode
  logic                           in_acc, load_acc, text_acc, cfg_acc;
  logic                           eval_go, hit;
  tpm_pkg::tpm_pos_t              cur_pos;
  logic                           pidx_in_len;
  logic [tpm_pkg::LEN_W-1:0]      wr_target;
  logic [tpm_pkg::CNT_W-1:0]      hits_next, files_next;

  // chain
  tpm_pkg::tpm_link_t             link [N+1];
  logic [N-1:0]                   ok_vec;
  logic [N-1:0]                   marker_vec;
  logic [N-1:0]                   pat_wr_vec;
  tpm_pkg::tpm_pos_t              sel_pos;

  assign in_stall_o  = (state_q != tpm_pkg::ST_IDLE) | eval_q;
  assign cfg_ready_o = (state_q == tpm_pkg::ST_IDLE) & ~eval_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign load_acc    = in_acc & (in_data_i.cmd == tpm_pkg::CMD_LOAD);
  assign text_acc    = in_acc & (in_data_i.cmd == tpm_pkg::CMD_TEXT);
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // ---------------------------------------------------------------------------
  // pattern store: raw symbols by index, read back in order on realignment
  // ---------------------------------------------------------------------------
  tpm_ram #(
    .WIDTH (tpm_pkg::SYM_W),
    .DEPTH (N)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc & (int'(in_data_i.pattern_index) < N)),
    .waddr_i (tpm_pkg::IDX_W'(in_data_i.pattern_index)),
    .wdata_i (in_data_i.symbol),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // realignment sequencer: shift p[0] .. p[len-1] into the head of the chain,
  // so cell k ends up holding p[len-1-k], a mask bit for k < len and the
  // marker on cell len-1 (the window start)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpm_pkg::ST_CLEAR;
      len_q   <= tpm_pkg::LEN_W'(1);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cnt_inc = cnt_q + tpm_pkg::LEN_W'(1);

  // per-cell controls come from here too, so the whole struct has one driver
  always_comb begin
    state_d         = state_q;
    len_d           = len_q;
    cnt_d           = cnt_q;
    ram_raddr       = '0;
    ctrl.text_shift = text_acc;
    ctrl.first      = in_data_i.first_in_file;
    ctrl.pat_wdata  = in_data_i.symbol;
    ctrl.pat_shift  = 1'b0;
    ctrl.pat_clear  = 1'b0;
    case (state_q)
      tpm_pkg::ST_IDLE: begin
        if (cfg_acc) begin
          // lengths above the chain depth saturate
          if (int'(cfg_data_i) > N) begin
            len_d = tpm_pkg::LEN_W'(N);
          end else begin
            len_d = tpm_pkg::LEN_W'(cfg_data_i);
          end
          state_d = tpm_pkg::ST_CLEAR;
        end
      end
      tpm_pkg::ST_CLEAR: begin
        ctrl.pat_clear = 1'b1;
        cnt_d          = '0;
        state_d        = (len_q == '0) ? tpm_pkg::ST_IDLE : tpm_pkg::ST_LOAD;
      end
      tpm_pkg::ST_LOAD: begin
        ctrl.pat_shift = 1'b1;
        ram_raddr      = cnt_inc[tpm_pkg::IDX_W-1:0];
        cnt_d          = cnt_inc;
        if (cnt_q == len_q - tpm_pkg::LEN_W'(1)) begin
          state_d = tpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpm_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // head of the chain
  // ---------------------------------------------------------------------------
  // a load within the current length goes straight to its aligned cell
  assign pidx_in_len = int'(in_data_i.pattern_index) < int'(len_q);
  assign wr_target   = len_q - tpm_pkg::LEN_W'(1)
                       - tpm_pkg::LEN_W'(in_data_i.pattern_index);

  // position of the incoming symbol; a new file restarts at line 1, column 1
  always_comb begin
    if (in_data_i.first_in_file) begin
      cur_pos.line   = tpm_pkg::CNT_ONE;
      cur_pos.column = tpm_pkg::CNT_ONE;
    end else begin
      cur_pos.line   = line_q;
      cur_pos.column = column_q;
    end
  end

  assign link[0] = '{symbol: in_data_i.symbol, pos: cur_pos, valid: 1'b1,
                     pattern: ram_rdata, mask: 1'b1, marker: (cnt_q == '0)};

  for (genvar k = 0; k < N; k++) begin : g_cell
    assign pat_wr_vec[k] = load_acc & pidx_in_len & (wr_target == tpm_pkg::LEN_W'(k));
    assign marker_vec[k] = link[k+1].marker;

    tpm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .pat_wr_i (pat_wr_vec[k]),
      .prev_i   (link[k]),
      .next_o   (link[k+1]),
      .ok_o     (ok_vec[k])
    );
  end

  // window start: the one marked cell, and-or selected
  always_comb begin
    sel_pos = '0;
    for (int k = 0; k < N; k++) begin
      sel_pos = sel_pos | (link[k+1].pos & {$bits(tpm_pkg::tpm_pos_t){marker_vec[k]}});
    end
  end

  // ---------------------------------------------------------------------------
  // line and column of the next text symbol
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= tpm_pkg::CNT_ONE;
      column_q <= tpm_pkg::CNT_ONE;
    end else if (text_acc) begin
      if (in_data_i.symbol == tpm_pkg::NEWLINE_CP) begin
        line_q   <= tpm_pkg::sat_inc(cur_pos.line);
        column_q <= tpm_pkg::CNT_ONE;
      end else begin
        line_q   <= cur_pos.line;
        column_q <= tpm_pkg::sat_inc(cur_pos.column);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // compare stage: follows the shift through eval_q, waits if a result is unread
  // ---------------------------------------------------------------------------
  assign eval_go    = eval_q & (~out_valid_q | ~out_stall_i);
  assign hit        = eval_go & (len_q != '0) & (&ok_vec);
  assign hits_next  = tpm_pkg::sat_inc(hits_q);
  assign files_next = file_has_hit_q ? files_q : tpm_pkg::sat_inc(files_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      hits_q         <= '0;
      files_q        <= '0;
      file_has_hit_q <= 1'b0;
    end else begin
      if (text_acc) begin
        eval_q <= 1'b1;
        if (in_data_i.first_in_file) begin
          file_has_hit_q <= 1'b0;
        end
      end else if (eval_go) begin
        eval_q <= 1'b0;
      end
      if (hit) begin
        out_valid_q    <= 1'b1;
        hits_q         <= hits_next;
        files_q        <= files_next;
        file_has_hit_q <= 1'b1;
      end else if (out_valid_q & ~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      out_q.match_line   <= sel_pos.line;
      out_q.match_column <= sel_pos.column;
      out_q.hits_so_far  <= hits_next;
      out_q.files_hit    <= files_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the compare stage never runs while the pattern chain is being rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(eval_q && (state_q != tpm_pkg::ST_IDLE)))
    else $error("compare pending during realignment");

  // once aligned, exactly one cell marks the window start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tpm_pkg::ST_IDLE) && (len_q != '0)) |-> $onehot(marker_vec))
    else $error("window start marker not one-hot");

  // a text transaction is always followed by a compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_acc |=> eval_q)
    else $error("text transaction without compare");

  // a new result only comes out of the compare stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(eval_q))
    else $error("result raised without compare");

  // files with hits never outnumber hits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    files_q <= hits_q)
    else $error("file hit count above hit count");

endmodule
